// ===== src/cmr_pkg.sv =====
`timescale 1ns / 1ps

package cmr_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_W         = 3;

   // request payload layout, lowest bit first
   localparam int REQ_DATA_W  = 112;
   localparam int REQ_CH_LO   = 0;
   localparam int REQ_TAG_LO  = 3;
   localparam int REQ_SMP_LO  = 19;
   localparam int REQ_END_BIT = 35;
   localparam int REQ_GAIN_LO = 36;
   localparam int REQ_VMIN_LO = 52;
   localparam int REQ_PER_LO  = 60;
   localparam int REQ_DLY_LO  = 92;

   // response payload layout, lowest bit first
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_OK_BIT   = 0;
   localparam int RSP_CH_LO    = 1;
   localparam int RSP_TAKEN    = 4;
   localparam int RSP_MIXV_BIT = 5;
   localparam int RSP_MIX_LO   = 6;
   localparam int RSP_DAC_LO   = 22;
   localparam int RSP_FIN_LO   = 30;

   localparam int SUM_W   = 46;
   localparam int PROD_W  = 40;
   localparam int SHIFT_Q = 22;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_ABORT  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic mul_first;    // sample * gain
      logic mul_second;   // product * volume
      logic accumulate;
      logic mark_played;
      logic close;
   } mac_ctrl_type;

   typedef struct packed {
      logic        mix_valid;
      logic [15:0] mix_sample;
      logic [7:0]  dac_level;
   } mix_type;

endpackage

// ===== src/cmr_mac.sv =====
`timescale 1ns / 1ps

module cmr_mac
   import cmr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       ctrl,
   input  logic signed [15:0] sample,
   input  logic [15:0]        gain,
   input  logic [7:0]         volume,
   output mix_type            mix
);

   logic signed [32:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic signed [49:0]       product;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     played_ff, played_in;
   logic [SUM_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic                     valid_ff, valid_in;
   logic [23:0]              quot;
   logic [14:0]              clamped;
   logic [15:0]              value;

   // one shared multiplier, operands picked per step
   always_comb begin
      if (ctrl.mul_second) begin
         mul_a = {prod_ff[31], prod_ff[31:0]};
         mul_b = {9'd0, volume};
      end else begin
         mul_a = {{17{sample[15]}}, sample};
         mul_b = {1'b0, gain};
      end
      product = mul_a * mul_b;
   end

   always_comb begin
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      played_in = played_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff;
      if (ctrl.mul_first || ctrl.mul_second) begin
         prod_in = product[PROD_W-1:0];
      end
      if (ctrl.accumulate) begin
         sum_in    = sum_ff + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         played_in = 1'b1;
      end
      if (ctrl.mark_played) begin
         played_in = 1'b1;
      end
      if (ctrl.close) begin
         neg_in    = sum_ff[SUM_W-1];
         mag_in    = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
         valid_in  = played_ff;
         sum_in    = '0;
         played_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         played_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         played_ff <= played_in;
         valid_ff  <= valid_in;
      end
      prod_ff <= prod_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
   end

   // truncate toward zero, clamp to +-32767
   always_comb begin
      quot    = mag_ff[SUM_W-1:SHIFT_Q];
      clamped = (quot > 24'd32767) ? 15'h7fff : quot[14:0];
      value   = neg_ff ? (16'd0 - {1'b0, clamped}) : {1'b0, clamped};
      mix.mix_valid  = valid_ff;
      mix.mix_sample = valid_ff ? value : 16'd0;
      mix.dac_level  = valid_ff ? {~value[15], value[14:8]} : 8'd0;
   end

endmodule

// ===== src/multichannel_audio_mixer_ramp_unit.sv =====
`timescale 1ns / 1ps
// channel   ports                                   tdata / tuser / tlast
// req       req_tvalid req_tready req_tdata        channel owner_tag sample sample_end gain
//           req_tuser req_tlast                    volume_min ramp_period delay_samples;
//                                                  tuser op; tlast last_of_frame
// rsp       rsp_tvalid rsp_tready rsp_tdata        start_ok assigned_channel sample_taken
//                                                  mix_valid mix_sample dac_level finished_mask
//
// an item passes the accept, execute and finish steps; a sample mixed into the frame
// also passes the second-multiply and accumulate steps, since the one 33x17 multiplier is
// used twice (sample*gain, then *volume) and the accumulator adds once; a frame end adds a magnitude/negate step
// reset is synchronous and clears all voices, abort marks, tags and the frame sum at once
// a finished result waits in the output register; a new item is accepted meanwhile, and
// the finish step holds only while that register is still full

module multichannel_audio_mixer_ramp_unit
   import cmr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel, owner_tag, sample, sample_end, gain, volume_min, ramp_period, delay_samples
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // start_ok, assigned_channel, sample_taken, mix_valid, mix_sample, dac_level,
   // finished_mask, two zero bits
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_MUL2  = 6'b000100,
      ST_ACC   = 6'b001000,
      ST_CLOSE = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // latched item
   op_type            it_op_ff;
   logic [CH_W-1:0]   it_ch_ff;
   logic [15:0]       it_tag_ff;
   logic signed [15:0] it_sample_ff;
   logic              it_end_ff;
   logic [15:0]       it_gain_ff;
   logic [7:0]        it_vmin_ff;
   logic [31:0]       it_period_ff;
   logic [19:0]       it_delay_ff;
   logic              it_last_ff;

   // voice table
   logic        active_ff  [NUM_CHANNELS];
   logic        active_in  [NUM_CHANNELS];
   logic        aborted_ff [NUM_CHANNELS];
   logic        aborted_in [NUM_CHANNELS];
   logic        tagv_ff    [NUM_CHANNELS];
   logic        tagv_in    [NUM_CHANNELS];
   logic [15:0] tag_ff     [NUM_CHANNELS];
   logic [15:0] tag_in     [NUM_CHANNELS];
   logic [19:0] delay_ff   [NUM_CHANNELS];
   logic [19:0] delay_in   [NUM_CHANNELS];
   logic [31:0] step_ff    [NUM_CHANNELS];
   logic [31:0] step_in    [NUM_CHANNELS];
   logic [31:0] timer_ff   [NUM_CHANNELS];
   logic [31:0] timer_in   [NUM_CHANNELS];
   logic [15:0] gain_ff    [NUM_CHANNELS];
   logic [15:0] gain_in    [NUM_CHANNELS];
   logic [7:0]  vol_ff     [NUM_CHANNELS];
   logic [7:0]  vol_in     [NUM_CHANNELS];

   // pending result
   logic              res_ok_ff, res_ok_in;
   logic [CH_W-1:0]   res_ch_ff, res_ch_in;
   logic              res_taken_ff, res_taken_in;
   logic [7:0]        res_fin_ff, res_fin_in;
   logic              closed_ff, closed_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic            free_hit, match_hit, frame_end, req_xfer;
   logic [CH_W-1:0] free_idx, match_idx;
   logic [31:0]     timer_dec;
   mac_ctrl_type    mac_ctrl;
   mix_type         mix;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign frame_end  = (it_op_ff == OP_SAMPLE) && it_last_ff;
   assign timer_dec  = timer_ff[it_ch_ff] - 32'd1;

   // lowest free channel and lowest channel holding the abort tag
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_hit = 1'b1;
            free_idx = CH_W'(i);
         end
         if (tagv_ff[i] && (tag_ff[i] == it_tag_ff)) begin
            match_hit = 1'b1;
            match_idx = CH_W'(i);
         end
      end
   end

   // item latch, payload only
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         it_op_ff     <= op_type'(req_tuser);
         it_ch_ff     <= req_tdata[REQ_CH_LO +: CH_W];
         it_tag_ff    <= req_tdata[REQ_TAG_LO +: 16];
         it_sample_ff <= req_tdata[REQ_SMP_LO +: 16];
         it_end_ff    <= req_tdata[REQ_END_BIT];
         it_gain_ff   <= req_tdata[REQ_GAIN_LO +: 16];
         it_vmin_ff   <= req_tdata[REQ_VMIN_LO +: 8];
         it_period_ff <= req_tdata[REQ_PER_LO +: 32];
         it_delay_ff  <= req_tdata[REQ_DLY_LO +: 20];
         it_last_ff   <= req_tlast;
      end
   end

   // sequencer and voice updates
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      aborted_in    = aborted_ff;
      tagv_in       = tagv_ff;
      tag_in        = tag_ff;
      delay_in      = delay_ff;
      step_in       = step_ff;
      timer_in      = timer_ff;
      gain_in       = gain_ff;
      vol_in        = vol_ff;
      res_ok_in     = res_ok_ff;
      res_ch_in     = res_ch_ff;
      res_taken_in  = res_taken_ff;
      res_fin_in    = res_fin_ff;
      closed_in     = closed_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mac_ctrl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_ok_in    = 1'b0;
               res_ch_in    = '0;
               res_taken_in = 1'b0;
               res_fin_in   = '0;
               closed_in    = 1'b0;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = frame_end ? ST_CLOSE : ST_FIN;
            case (it_op_ff)
               OP_START: begin
                  if (free_hit) begin
                     active_in[free_idx]  = 1'b1;
                     aborted_in[free_idx] = 1'b0;
                     tagv_in[free_idx]    = 1'b1;
                     tag_in[free_idx]     = it_tag_ff;
                     gain_in[free_idx]    = it_gain_ff;
                     vol_in[free_idx]     = it_vmin_ff;
                     step_in[free_idx]    = it_period_ff;
                     timer_in[free_idx]   = it_period_ff;
                     delay_in[free_idx]   = it_delay_ff;
                     res_ok_in            = 1'b1;
                     res_ch_in            = free_idx;
                  end
               end
               OP_ABORT: begin
                  if (match_hit) begin
                     aborted_in[match_idx] = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  // abort marks on idle channels survive
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     if (active_ff[i]) begin
                        res_fin_in[i] = !aborted_ff[i];
                        active_in[i]  = 1'b0;
                        aborted_in[i] = 1'b0;
                     end
                  end
               end
               OP_SAMPLE: begin
                  if (active_ff[it_ch_ff]) begin
                     if (!aborted_ff[it_ch_ff] && (delay_ff[it_ch_ff] != 20'd0)) begin
                        // still in start delay: counts as playing
                        mac_ctrl.mark_played = 1'b1;
                        delay_in[it_ch_ff]   = delay_ff[it_ch_ff] - 20'd1;
                     end else if (aborted_ff[it_ch_ff] || it_end_ff) begin
                        res_fin_in[it_ch_ff] = !aborted_ff[it_ch_ff];
                        active_in[it_ch_ff]  = 1'b0;
                        aborted_in[it_ch_ff] = 1'b0;
                     end else begin
                        mac_ctrl.mul_first = 1'b1;
                        res_taken_in       = 1'b1;
                        state_in           = ST_MUL2;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MUL2: begin
            mac_ctrl.mul_second = 1'b1;
            state_in            = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.accumulate = 1'b1;
            // volume ramp after the product has used the old volume
            if (step_ff[it_ch_ff] != 32'd0) begin
               if (timer_dec == 32'd0) begin
                  timer_in[it_ch_ff] = step_ff[it_ch_ff];
                  vol_in[it_ch_ff]   = vol_ff[it_ch_ff] + 8'd1;
               end else begin
                  timer_in[it_ch_ff] = timer_dec;
               end
            end
            state_in = frame_end ? ST_CLOSE : ST_FIN;
         end
         ST_CLOSE: begin
            mac_ctrl.close = 1'b1;
            closed_in      = 1'b1;
            state_in       = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[RSP_OK_BIT]        = res_ok_ff;
               rsp_tdata_in[RSP_CH_LO +: CH_W] = res_ch_ff;
               rsp_tdata_in[RSP_TAKEN]         = res_taken_ff;
               rsp_tdata_in[RSP_FIN_LO +: 8]   = res_fin_ff;
               if (closed_ff) begin
                  rsp_tdata_in[RSP_MIXV_BIT]      = mix.mix_valid;
                  rsp_tdata_in[RSP_MIX_LO +: 16]  = mix.mix_sample;
                  rsp_tdata_in[RSP_DAC_LO +: 8]   = mix.dac_level;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            active_ff[i]  <= 1'b0;
            aborted_ff[i] <= 1'b0;
            tagv_ff[i]    <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         active_ff     <= active_in;
         aborted_ff    <= aborted_in;
         tagv_ff       <= tagv_in;
      end
      tag_ff       <= tag_in;
      delay_ff     <= delay_in;
      step_ff      <= step_in;
      timer_ff     <= timer_in;
      gain_ff      <= gain_in;
      vol_ff       <= vol_in;
      res_ok_ff    <= res_ok_in;
      res_ch_ff    <= res_ch_in;
      res_taken_ff <= res_taken_in;
      res_fin_ff   <= res_fin_in;
      closed_ff    <= closed_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // shared multiplier, frame accumulator and frame output scaling
   cmr_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (it_sample_ff),
      .gain   (gain_ff[it_ch_ff]),
      .volume (vol_ff[it_ch_ff]),
      .mix    (mix)
   );

endmodule

// ===== src/cmr_checker.sv =====
`timescale 1ns / 1ps

module cmr_checker
   import cmr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [15:0] mix_s;
   assign mix_s = rsp_tdata[RSP_MIX_LO +: 16];

   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one item at a time: no transfer in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no frame output means zero mix fields
   a_mix_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_MIXV_BIT] |->
         mix_s == 16'd0 && rsp_tdata[RSP_DAC_LO +: 8] == 8'd0)
      else $error("mix fields set without frame output");

   // dac byte follows the mix sample and the clamp keeps off the most negative code
   a_dac: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_MIXV_BIT] |->
         rsp_tdata[RSP_DAC_LO +: 8] == {~mix_s[15], mix_s[14:8]} && mix_s != 16'h8000)
      else $error("dac level or clamp wrong");

   // a successful start reports nothing else
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_OK_BIT] |->
         !rsp_tdata[RSP_TAKEN] && rsp_tdata[RSP_FIN_LO +: 8] == 8'd0
         && !rsp_tdata[RSP_MIXV_BIT])
      else $error("start result mixed with other results");

endmodule

bind multichannel_audio_mixer_ramp_unit cmr_checker u_cmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import cmr_pkg::*;

   // one request transfer, fields as the mixer sees them
   typedef struct packed {
      op_type      op;
      logic [2:0]  channel;
      logic [15:0] owner_tag;
      logic [15:0] sample;
      logic        sample_end;
      logic [15:0] gain;
      logic [7:0]  volume_min;
      logic [31:0] ramp_period;
      logic [19:0] delay_samples;
      logic        last_of_frame;
   } voice_req_type;

   // one response transfer
   typedef struct packed {
      bit        start_ok;
      bit [2:0]  assigned_channel;
      bit        sample_taken;
      bit        mix_valid;
      bit [15:0] mix_sample;
      bit [7:0]  dac_level;
      bit [7:0]  finished_mask;
   } mix_result_type;

   // voice bank model plus the queue of responses still owed by the mixer
   class mixer_scoreboard;
      bit             voice_on      [NUM_CHANNELS];
      bit             voice_aborted [NUM_CHANNELS];
      bit             tag_known     [NUM_CHANNELS];
      bit [15:0]      tag_of        [NUM_CHANNELS];
      bit [19:0]      delay_left    [NUM_CHANNELS];
      bit [31:0]      ramp_len      [NUM_CHANNELS];
      bit [31:0]      ramp_count    [NUM_CHANNELS];
      bit [15:0]      voice_gain    [NUM_CHANNELS];
      bit [7:0]       voice_vol     [NUM_CHANNELS];
      bit [45:0]      frame_acc;
      bit             frame_live;
      mix_result_type owed_q[$];
      int             errors;
      int             starts_ok;
      int             samples_mixed;
      int             frames_out;
      int             voices_finished;

      function int pending();
         return owed_q.size();
      endfunction

      // stops a voice; returns its finish bit unless it was aborted
      function bit [7:0] retire_voice(int c);
         bit [7:0] fin;
         fin = '0;
         if (voice_on[c]) begin
            if (!voice_aborted[c])
               fin[c] = 1'b1;
            voice_on[c]      = 1'b0;
            voice_aborted[c] = 1'b0;
         end
         return fin;
      endfunction

      function void note_request(voice_req_type r);
         mix_result_type e;
         bit             found;
         int             i;
         int             c;
         longint         s;
         longint         g;
         longint         v;
         longint         prod;
         bit             neg;
         bit [45:0]      mag;
         int             q;
         int             level;
         int             biased;
         e     = '0;
         found = 1'b0;
         case (r.op)
            OP_START: begin
               for (i = 0; i < NUM_CHANNELS; i++) begin
                  if (!voice_on[i] && !found) begin
                     found            = 1'b1;
                     voice_on[i]      = 1'b1;
                     voice_aborted[i] = 1'b0;
                     tag_known[i]     = 1'b1;
                     tag_of[i]        = r.owner_tag;
                     voice_gain[i]    = r.gain;
                     voice_vol[i]     = r.volume_min;
                     ramp_len[i]      = r.ramp_period;
                     ramp_count[i]    = r.ramp_period;
                     delay_left[i]    = r.delay_samples;
                     e.start_ok         = 1'b1;
                     e.assigned_channel = i[2:0];
                     starts_ok++;
                  end
               end
            end
            OP_ABORT: begin
               // first matching tag wins, even on an idle channel
               for (i = 0; i < NUM_CHANNELS; i++) begin
                  if (tag_known[i] && tag_of[i] == r.owner_tag && !found) begin
                     found            = 1'b1;
                     voice_aborted[i] = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               for (i = 0; i < NUM_CHANNELS; i++)
                  e.finished_mask |= retire_voice(i);
            end
            default: begin
               c = r.channel;
               if (voice_on[c]) begin
                  if (!voice_aborted[c] && delay_left[c] != 0) begin
                     frame_live    = 1'b1;
                     delay_left[c] = delay_left[c] - 20'd1;
                  end else if (voice_aborted[c] || r.sample_end) begin
                     e.finished_mask |= retire_voice(c);
                  end else begin
                     s          = $signed(r.sample);
                     g          = voice_gain[c];
                     v          = voice_vol[c];
                     prod       = s * g * v;
                     frame_acc  = frame_acc + prod[45:0];
                     frame_live = 1'b1;
                     e.sample_taken = 1'b1;
                     samples_mixed++;
                     if (ramp_len[c] != 0) begin
                        ramp_count[c] = ramp_count[c] - 32'd1;
                        if (ramp_count[c] == 0) begin
                           ramp_count[c] = ramp_len[c];
                           voice_vol[c]  = voice_vol[c] + 8'd1;
                        end
                     end
                  end
               end
               if (r.last_of_frame) begin
                  if (frame_live) begin
                     neg = frame_acc[45];
                     mag = neg ? (~frame_acc + 46'd1) : frame_acc;
                     q   = int'(mag >> SHIFT_Q);
                     if (q > 32767)
                        q = 32767;
                     level  = neg ? -q : q;
                     biased = level + 32768;
                     e.mix_valid  = 1'b1;
                     e.mix_sample = level[15:0];
                     e.dac_level  = biased[15:8];
                     frames_out++;
                  end
                  frame_acc  = '0;
                  frame_live = 1'b0;
               end
            end
         endcase
         voices_finished += $countones(e.finished_mask);
         owed_q.push_back(e);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] d);
         mix_result_type e;
         if (owed_q.size() == 0) begin
            $error("response transfer with nothing outstanding: %h", d);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         compare_field("start_ok", e.start_ok, d[RSP_OK_BIT]);
         compare_field("assigned_channel", e.assigned_channel, d[RSP_CH_LO +: CH_W]);
         compare_field("sample_taken", e.sample_taken, d[RSP_TAKEN]);
         compare_field("mix_valid", e.mix_valid, d[RSP_MIXV_BIT]);
         compare_field("mix_sample", int'($signed(e.mix_sample)),
                       int'($signed(d[RSP_MIX_LO +: 16])));
         compare_field("dac_level", e.dac_level, d[RSP_DAC_LO +: 8]);
         compare_field("finished_mask", e.finished_mask, d[RSP_FIN_LO +: 8]);
         compare_field("pad", 0, d[RSP_DATA_W-1 : RSP_FIN_LO+8]);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // channel, owner_tag, sample, sample_end, gain, volume_min, ramp_period, delay_samples
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // op
   logic [1:0]            req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // start_ok, assigned_channel, sample_taken, mix_valid, mix_sample, dac_level,
   // finished_mask, two zero bits
   logic [RSP_DATA_W-1:0] rsp_tdata;

   mixer_scoreboard sb;
   bit              calm;      // last stretch of the run: no idling anywhere
   bit              gaps_on;   // sender may leave gaps between transfers
   bit              hold_req;  // asks the receiver for one long hold-off

   multichannel_audio_mixer_ramp_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response monitor: sample at the rising edge, pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // response side: random stall bursts, plus the long hold-off on request
   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            // block takes one more request after its result register is full, then holds in its finish step
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("FAIL multichannel_audio_mixer_ramp_unit");
      $finish;
   end

   function automatic voice_req_type voice_req(op_type op, logic [2:0] ch, logic [15:0] tag,
                                               logic [15:0] smp, logic smp_end,
                                               logic [15:0] gain, logic [7:0] vmin,
                                               logic [31:0] period, logic [19:0] dly,
                                               logic last);
      voice_req_type r;
      r.op            = op;
      r.channel       = ch;
      r.owner_tag     = tag;
      r.sample        = smp;
      r.sample_end    = smp_end;
      r.gain          = gain;
      r.volume_min    = vmin;
      r.ramp_period   = period;
      r.delay_samples = dly;
      r.last_of_frame = last;
      return r;
   endfunction

   // tags mostly from a small pool so that aborts and starts collide
   function automatic logic [15:0] pool_tag();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return 16'($urandom_range(0, 7));
      else if (pick == 7)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // mostly well-formed voice traffic aimed at live channels, some noise
   function automatic voice_req_type random_item();
      voice_req_type r;
      int            live[$];
      int            k;
      int            pick;
      for (k = 0; k < NUM_CHANNELS; k++)
         if (sb.voice_on[k])
            live.push_back(k);
      r.channel       = 3'($urandom);
      r.owner_tag     = 16'($urandom);
      r.sample        = 16'($urandom);
      r.sample_end    = ($urandom_range(0, 19) == 0);
      r.gain          = 16'($urandom);
      r.volume_min    = 8'($urandom);
      r.ramp_period   = $urandom;
      r.delay_samples = 20'($urandom);
      r.last_of_frame = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 11 || (live.size() == 0 && pick < 50)) begin
         r.op        = OP_START;
         r.owner_tag = pool_tag();
         case ($urandom_range(0, 3))
            0: r.gain = 16'hFFFF;
            1: r.gain = 16'($urandom_range(0, 256));
            2: r.gain = 16'd16384;
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0)
            r.volume_min = 8'd128;
         case ($urandom_range(0, 9))
            0, 1, 2: r.ramp_period = '0;
            3, 4, 5, 6: r.ramp_period = $urandom_range(1, 4);
            7: r.ramp_period = 32'hFFFF_FFFF;
            default: ;
         endcase
         // long delays would park a channel for the rest of the run
         case ($urandom_range(0, 39))
            0, 1: ;
            2: r.delay_samples = 20'hF_FFFF;
            default: r.delay_samples = ($urandom_range(0, 1) == 0) ? '0 :
                                       20'($urandom_range(1, 3));
         endcase
      end else if (pick < 16) begin
         r.op = OP_ABORT;
         k    = $urandom_range(0, NUM_CHANNELS-1);
         r.owner_tag = ($urandom_range(0, 3) != 0 && sb.tag_known[k]) ? sb.tag_of[k] :
                       pool_tag();
      end else if (pick < 18) begin
         r.op = OP_CLEAR;
      end else begin
         r.op = OP_SAMPLE;
         if (live.size() != 0 && $urandom_range(0, 6) != 0)
            r.channel = 3'(live[$urandom_range(0, live.size()-1)]);
      end
      return r;
   endfunction

   // one request transfer, with an optional gap after it
   task automatic send(input voice_req_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tlast  <= r.last_of_frame;
      req_tdata  <= {r.delay_samples, r.ramp_period, r.volume_min, r.gain,
                     r.sample_end, r.sample, r.owner_tag, r.channel};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
      if (gaps_on && !hold_req && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // one full-scale voice over a long frame: clamps, then wraps the 46-bit sum
   task automatic loud_frame(input logic [15:0] level);
      int k;
      send(voice_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(voice_req(OP_START, 0, 16'h5A5A, 0, 0, 16'hFFFF, 8'hFF, 0, 0, 0));
      for (k = 0; k < 90; k++)
         send(voice_req(OP_SAMPLE, 0, 0, level, 0, 0, 0, 0, 0, k == 89));
      send(voice_req(OP_SAMPLE, 0, 0, 0, 1, 0, 0, 0, 0, 1));
   endtask

   initial begin
      int n;
      int k;
      sb      = new();
      calm    = 1'b0;
      gaps_on = 1'b1;
      hold_req = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: sample to an idle channel at frame end gives no frame
      send(voice_req(OP_SAMPLE, 7, 0, 16'h1234, 0, 0, 0, 0, 0, 1));
      // abort before any tag exists
      send(voice_req(OP_ABORT, 0, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
      // fill all channels with extreme settings
      send(voice_req(OP_START, 0, 16'h0001, 0, 0, 16'hFFFF, 8'hFF, 32'd1, 20'd0, 0));
      send(voice_req(OP_START, 0, 16'hFFFF, 0, 0, 16'h0000, 8'h00, 32'd0, 20'hF_FFFF, 0));
      send(voice_req(OP_START, 0, 16'h1234, 0, 0, 16'd16384, 8'd128, 32'hFFFF_FFFF, 20'd0,
                     0));
      for (k = 0; k < 5; k++)
         send(voice_req(OP_START, 0, 16'(16 + k), 0, 0, 16'h8000, 8'h80, 32'd3, 20'd1, 0));
      // no free channel left
      send(voice_req(OP_START, 0, 16'h7777, 0, 0, 16'h1111, 8'h22, 32'd5, 20'd6, 0));
      // full-scale sample, volume wraps from 255 to 0 with a ramp of one
      send(voice_req(OP_SAMPLE, 0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0));
      send(voice_req(OP_SAMPLE, 0, 0, 16'h8000, 0, 0, 0, 0, 0, 1));
      // delayed voice plays silence: frame out at zero
      send(voice_req(OP_SAMPLE, 1, 0, 16'h4000, 1, 0, 0, 0, 0, 1));
      // abort skips the delay and ends without a finish bit
      send(voice_req(OP_ABORT, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      send(voice_req(OP_SAMPLE, 1, 0, 16'h0001, 0, 0, 0, 0, 0, 0));
      // abort mark on an idle channel, then a new start clears it
      send(voice_req(OP_ABORT, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
      send(voice_req(OP_START, 0, 16'h00AA, 0, 0, 16'h0100, 8'h40, 32'd2, 20'd0, 0));
      // sound ends normally
      send(voice_req(OP_SAMPLE, 2, 0, 16'h0000, 1, 0, 0, 0, 0, 0));
      // clear all, frame end flag ignored on this op
      send(voice_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send(voice_req(OP_SAMPLE, 3, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1));

      // random traffic
      for (n = 0; n < 1600; n++) begin
         calm    = (n >= 1400);
         gaps_on = !calm && (n % 160) < 120;
         if (n == 300 || n == 950)
            hold_req = 1'b1;
         if (n == 500)
            loud_frame(16'h8000);
         if (n == 1100)
            loud_frame(16'h7FFF);
         send(random_item());
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (32) @(posedge clock);

      $display("covered %0d starts, %0d samples mixed, %0d frames out, %0d voices finished",
               sb.starts_ok, sb.samples_mixed, sb.frames_out, sb.voices_finished);
      $display("with ramp and volume wrap, delays, aborts, clears and clamped or wrapped sums");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS multichannel_audio_mixer_ramp_unit");
      else
         $display("FAIL multichannel_audio_mixer_ramp_unit");
      $finish;
   end

endmodule
